// File: hdl/mts_pkg.sv
`default_nettype none
// Shared types, codes and helpers of the Morton tile texture swizzle.
package mts_pkg;

  localparam int unsigned MAX_DIM = 1024;
  localparam int unsigned DIM_W = 11;
  localparam int unsigned POS_W = 10;
  localparam int unsigned OFS_W = 22;
  localparam int unsigned DATA_W = 48;
  localparam int unsigned IDX_W = 3;

  localparam logic CMD_START = 1'b0;
  localparam logic CMD_PAIR = 1'b1;

  localparam logic [1:0] ST_OK = 2'd0;
  localparam logic [1:0] ST_INVALID = 2'd1;
  localparam logic [1:0] ST_IDLE = 2'd2;

  localparam logic [1:0] FMT_RGB8 = 2'd0;
  localparam logic [1:0] FMT_RGB565 = 2'd1;

  localparam logic [IDX_W-1:0] REG_PIC_W = 3'd0;
  localparam logic [IDX_W-1:0] REG_PIC_H = 3'd1;
  localparam logic [IDX_W-1:0] REG_WIN_X = 3'd2;
  localparam logic [IDX_W-1:0] REG_WIN_Y = 3'd3;
  localparam logic [IDX_W-1:0] REG_TEX_W = 3'd4;
  localparam logic [IDX_W-1:0] REG_TEX_H = 3'd5;
  localparam logic [IDX_W-1:0] REG_FORMAT = 3'd6;

  typedef enum logic {
    WK_STATUS,
    WK_PAIR
  } work_kind_t;

  typedef struct packed {
    work_kind_t kind;
    logic [1:0] status;
    logic [POS_W-1:0] row;
    logic [POS_W-1:0] col;
    logic three_byte;
    logic [DIM_W-1:0] pic_w;
    logic [DIM_W-1:0] tex_w;
    logic [DIM_W-1:0] start_x;
    logic [DIM_W-1:0] start_y;
    logic [DATA_W-1:0] data;
    logic last;
  } work_t;

  function automatic logic [5:0] morton8(input logic [2:0] x, input logic [2:0] y);
    morton8 = {y[2], x[2], y[1], x[1], y[0], x[0]};
  endfunction

  function automatic logic dim_ok(input logic [DIM_W-1:0] t);
    dim_ok = (t != '0) && (t[2:0] == 3'd0) && (t <= DIM_W'(MAX_DIM));
  endfunction

endpackage
`default_nettype wire

// File: hdl/mts_if.sv
`default_nettype none
// Channel interfaces for command items, result items and register writes.
interface mts_req_if;
  logic valid;
  logic ready;
  logic command;
  logic [mts_pkg::DATA_W-1:0] pixel_pair;
  modport source (output valid, command, pixel_pair, input ready);
  modport sink (input valid, command, pixel_pair, output ready);
endinterface

interface mts_rsp_if;
  logic valid;
  logic ready;
  logic [1:0] status;
  logic [mts_pkg::OFS_W-1:0] source_offset;
  logic [mts_pkg::OFS_W-1:0] texture_offset;
  logic [mts_pkg::DATA_W-1:0] pair_data;
  logic last_pair;
  modport source (output valid, status, source_offset, texture_offset, pair_data, last_pair,
                  input ready);
  modport sink (input valid, status, source_offset, texture_offset, pair_data, last_pair,
                output ready);
endinterface

interface mts_cfg_if;
  logic valid;
  logic ready;
  logic [mts_pkg::IDX_W-1:0] index;
  logic [mts_pkg::DIM_W-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

// File: hdl/mts_front.sv
`default_nettype none
// Front end: register bank, start validation, window walk and work records.
module mts_front (
  input  wire logic       clk,
  input  wire logic       rst,
  mts_cfg_if.sink         cfg,
  mts_req_if.sink         req,
  input  wire logic       queue_full,
  output logic            push,
  output mts_pkg::work_t  push_data
);

  logic [mts_pkg::DIM_W-1:0] pic_w;
  logic [mts_pkg::DIM_W-1:0] pic_h;
  logic [mts_pkg::DIM_W-1:0] win_x;
  logic [mts_pkg::DIM_W-1:0] win_y;
  logic [mts_pkg::DIM_W-1:0] tex_w;
  logic [mts_pkg::DIM_W-1:0] tex_h;
  logic [1:0] pix_fmt;

  logic [mts_pkg::POS_W-1:0] current_row;
  logic [mts_pkg::POS_W-1:0] current_column;
  logic [mts_pkg::DIM_W-1:0] rows_to_copy;
  logic [mts_pkg::DIM_W-1:0] columns_to_copy;
  logic copy_active;

  logic lat_three;
  logic [mts_pkg::DIM_W-1:0] lat_pw;
  logic [mts_pkg::DIM_W-1:0] lat_tw;
  logic [mts_pkg::DIM_W-1:0] lat_sx;
  logic [mts_pkg::DIM_W-1:0] lat_sy;

  logic invalid;
  logic [mts_pkg::DIM_W-1:0] y_room;
  logic [mts_pkg::DIM_W-1:0] x_room;
  logic [mts_pkg::DIM_W-1:0] y_clip;
  logic [mts_pkg::DIM_W-1:0] x_clip;
  logic row_end;
  logic last_row;

  assign cfg.ready = 1'b1;
  assign req.ready = !queue_full;
  assign push = req.valid && !queue_full;

  always_ff @(posedge clk) begin
    if (rst) begin
      pic_w <= mts_pkg::DIM_W'(1024);
      pic_h <= mts_pkg::DIM_W'(1024);
      win_x <= '0;
      win_y <= '0;
      tex_w <= mts_pkg::DIM_W'(1024);
      tex_h <= mts_pkg::DIM_W'(1024);
      pix_fmt <= mts_pkg::FMT_RGB565;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        mts_pkg::REG_PIC_W: pic_w <= cfg.data;
        mts_pkg::REG_PIC_H: pic_h <= cfg.data;
        mts_pkg::REG_WIN_X: win_x <= cfg.data;
        mts_pkg::REG_WIN_Y: win_y <= cfg.data;
        mts_pkg::REG_TEX_W: tex_w <= cfg.data;
        mts_pkg::REG_TEX_H: tex_h <= cfg.data;
        mts_pkg::REG_FORMAT: pix_fmt <= cfg.data[1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    invalid = (pix_fmt != mts_pkg::FMT_RGB8 && pix_fmt != mts_pkg::FMT_RGB565) ||
              (win_x > pic_w) || (win_y > pic_h) ||
              !mts_pkg::dim_ok(tex_w) || !mts_pkg::dim_ok(tex_h) ||
              (pic_w > mts_pkg::DIM_W'(mts_pkg::MAX_DIM)) ||
              (pic_h > mts_pkg::DIM_W'(mts_pkg::MAX_DIM));
    y_room = pic_h - win_y;
    x_room = pic_w - win_x;
    y_clip = (tex_h < y_room) ? tex_h : y_room;
    x_clip = (tex_w < x_room) ? tex_w : x_room;
    row_end = ({2'b0, current_column} + 12'd2) >= {1'b0, columns_to_copy};
    last_row = ({1'b0, current_row} + 11'd1) >= rows_to_copy;
  end

  always_comb begin
    push_data.kind = mts_pkg::WK_STATUS;
    push_data.status = mts_pkg::ST_OK;
    push_data.row = current_row;
    push_data.col = current_column;
    push_data.three_byte = lat_three;
    push_data.pic_w = lat_pw;
    push_data.tex_w = lat_tw;
    push_data.start_x = lat_sx;
    push_data.start_y = lat_sy;
    push_data.data = lat_three ? req.pixel_pair : {16'b0, req.pixel_pair[31:0]};
    push_data.last = 1'b0;
    priority if (req.command == mts_pkg::CMD_START) begin
      push_data.status = invalid ? mts_pkg::ST_INVALID : mts_pkg::ST_OK;
    end else if (!copy_active) begin
      push_data.status = mts_pkg::ST_IDLE;
    end else begin
      push_data.kind = mts_pkg::WK_PAIR;
      push_data.last = row_end && last_row;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      current_row <= '0;
      current_column <= '0;
      rows_to_copy <= '0;
      columns_to_copy <= '0;
      copy_active <= 1'b0;
    end else if (push) begin
      if (req.command == mts_pkg::CMD_START) begin
        copy_active <= 1'b0;
        if (!invalid) begin
          rows_to_copy <= y_clip;
          columns_to_copy <= x_clip;
          current_row <= '0;
          current_column <= '0;
          copy_active <= (y_clip != '0) && (x_clip != '0);
        end
      end else if (copy_active) begin
        if (row_end) begin
          current_column <= '0;
          if (last_row) begin
            copy_active <= 1'b0;
            current_row <= '0;
          end else begin
            current_row <= current_row + 10'd1;
          end
        end else begin
          current_column <= current_column + 10'd2;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push && req.command == mts_pkg::CMD_START && !invalid) begin
      lat_three <= (pix_fmt == mts_pkg::FMT_RGB8);
      lat_pw <= pic_w;
      lat_tw <= tex_w;
      lat_sx <= win_x;
      lat_sy <= win_y;
    end
  end

  a_col_in_window: assert property (@(posedge clk) disable iff (rst)
    copy_active |-> ({1'b0, current_column} < columns_to_copy))
    else $error("Column walked past the clipped window.");

  a_row_in_window: assert property (@(posedge clk) disable iff (rst)
    copy_active |-> ({1'b0, current_row} < rows_to_copy))
    else $error("Row walked past the clipped window.");

  a_col_even: assert property (@(posedge clk) disable iff (rst)
    current_column[0] == 1'b0)
    else $error("Column of a pair is odd.");

endmodule
`default_nettype wire

// File: hdl/mts_queue.sv
`default_nettype none
// Two-entry queue of work records between the front and back ends.
module mts_queue (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            push,
  input  wire mts_pkg::work_t  push_data,
  output logic                 full,
  input  wire logic            pop,
  output mts_pkg::work_t       pop_data,
  output logic                 empty
);

  mts_pkg::work_t entries [2];
  logic wr_ptr;
  logic rd_ptr;
  logic [1:0] count;

  assign full = (count == 2'd2);
  assign empty = (count == 2'd0);
  assign pop_data = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count <= '0;
    end else begin
      if (push) wr_ptr <= !wr_ptr;
      if (pop) rd_ptr <= !rd_ptr;
      count <= count + 2'(push) - 2'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) entries[wr_ptr] <= push_data;
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    full |-> !push)
    else $error("Item pushed into a full queue.");

  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    empty |-> !pop)
    else $error("Item popped from an empty queue.");

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count != 2'd3)
    else $error("Queue count out of range.");

endmodule
`default_nettype wire

// File: hdl/mts_back.sv
`default_nettype none
// Back end: three-stage offset pipeline whose last stage is the result register.
module mts_back (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       empty,
  input  wire mts_pkg::work_t work,
  output logic            pop,
  mts_rsp_if.source       rsp
);

  typedef struct packed {
    mts_pkg::work_kind_t kind;
    logic [1:0] status;
    logic three_byte;
    logic [mts_pkg::DATA_W-1:0] data;
    logic last;
  } tag_t;

  logic advance;
  logic s1_valid;
  logic s2_valid;
  logic out_valid;
  tag_t s1_tag;
  tag_t s2_tag;

  logic [22:0] src_prod;
  logic [11:0] src_col;
  logic [17:0] tile_prod;
  logic [12:0] tex_low;
  logic [mts_pkg::OFS_W-1:0] spos;
  logic [mts_pkg::OFS_W-1:0] tpos;

  logic [11:0] row_sum;
  logic [mts_pkg::OFS_W-1:0] spos_next;
  logic [mts_pkg::OFS_W-1:0] tpos_next;
  logic [mts_pkg::OFS_W-1:0] src_scaled;
  logic [mts_pkg::OFS_W-1:0] tex_scaled;

  assign advance = !out_valid || rsp.ready;
  assign pop = advance && !empty;
  assign rsp.valid = out_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
      out_valid <= 1'b0;
    end else if (advance) begin
      s1_valid <= !empty;
      s2_valid <= s1_valid;
      out_valid <= s2_valid;
    end
  end

  always_comb begin
    row_sum = {2'b0, work.row} + {1'b0, work.start_y};
    spos_next = src_prod[mts_pkg::OFS_W-1:0] + {10'b0, src_col};
    tpos_next = {1'b0, tile_prod, 3'b0} + {9'b0, tex_low};
    src_scaled = s2_tag.three_byte ? ({spos[20:0], 1'b0} + spos) : {spos[20:0], 1'b0};
    tex_scaled = s2_tag.three_byte ? ({tpos[20:0], 1'b0} + tpos) : {tpos[20:0], 1'b0};
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      src_prod <= {11'b0, row_sum} * {12'b0, work.pic_w};
      src_col <= {2'b0, work.col} + {1'b0, work.start_x};
      tile_prod <= {11'b0, work.row[9:3]} * {7'b0, work.tex_w};
      tex_low <= {work.col[9:3], 6'b0} + {7'b0, mts_pkg::morton8(work.col[2:0], work.row[2:0])};
      s1_tag <= '{kind: work.kind, status: work.status, three_byte: work.three_byte,
                  data: work.data, last: work.last};
      spos <= spos_next;
      tpos <= tpos_next;
      s2_tag <= s1_tag;
      rsp.status <= s2_tag.status;
      if (s2_tag.kind == mts_pkg::WK_PAIR) begin
        rsp.source_offset <= src_scaled;
        rsp.texture_offset <= tex_scaled;
        rsp.pair_data <= s2_tag.data;
        rsp.last_pair <= s2_tag.last;
      end else begin
        rsp.source_offset <= '0;
        rsp.texture_offset <= '0;
        rsp.pair_data <= '0;
        rsp.last_pair <= 1'b0;
      end
    end
  end

  a_last_is_ok: assert property (@(posedge clk) disable iff (rst)
    (rsp.valid && rsp.last_pair) |-> (rsp.status == mts_pkg::ST_OK))
    else $error("Final pair mark on a status result.");

  a_status_zero_fields: assert property (@(posedge clk) disable iff (rst)
    (rsp.valid && rsp.status != mts_pkg::ST_OK) |->
      (rsp.source_offset == '0 && rsp.texture_offset == '0))
    else $error("Status result carries an offset.");

  a_pop_moves: assert property (@(posedge clk) disable iff (rst)
    pop |=> s1_valid)
    else $error("Popped item lost before the first stage.");

endmodule
`default_nettype wire

// File: hdl/morton_tile_texture_swizzle.sv
`default_nettype none
// Top level of the Morton tile texture swizzle.
// The block takes one item per cycle while the queue is not full: a start command or a
// pixel pair. Each item yields one result: the item waits in the two-entry queue behind
// the front end and then passes the multiply, sum and pixel-size stages of the offset
// pipeline, whose last stage is the result register; when the result side stalls, the
// queue and pipeline hold up to five items before the item side stalls.
// Register writes are taken in any cycle and take effect at the next valid start command,
// which latches the format, picture width, texture width and window origin.
module morton_tile_texture_swizzle (
  input wire logic clk,
  input wire logic rst,
  mts_cfg_if.sink  cfg,
  mts_req_if.sink  req,
  mts_rsp_if.source rsp
);

  logic queue_full;
  logic queue_empty;
  logic push;
  logic pop;
  mts_pkg::work_t push_data;
  mts_pkg::work_t pop_data;

  mts_front u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .req        (req),
    .queue_full (queue_full),
    .push       (push),
    .push_data  (push_data)
  );

  mts_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .full      (queue_full),
    .pop       (pop),
    .pop_data  (pop_data),
    .empty     (queue_empty)
  );

  mts_back u_back (
    .clk   (clk),
    .rst   (rst),
    .empty (queue_empty),
    .work  (pop_data),
    .pop   (pop),
    .rsp   (rsp)
  );

endmodule
`default_nettype wire
